// ----- design/ipd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the +IPD frame parser.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int IPD_MAX_PAYLOAD = 255;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Position inside the frame header; the payload phase follows the colon.
    typedef enum logic [3:0] {
        POS_I       = 4'd1,
        POS_P       = 4'd2,
        POS_D       = 4'd3,
        POS_COMMA1  = 4'd4,
        POS_ID      = 4'd5,
        POS_COMMA2  = 4'd6,
        POS_LEN     = 4'd7,
        POS_COLON   = 4'd8,
        POS_PAYLOAD = 4'd9
    } ipd_pos_t;

    // Packed so that conn_id lands in the lowest bits of the output word.
    typedef struct packed {
        logic [1:0] command;
        logic       command_valid;
        logic [7:0] first_byte;
        logic [7:0] payload_count;
        logic [3:0] declared_length;
        logic [3:0] conn_id;
    } ipd_result_t;

    localparam int IPD_RESULT_W = $bits(ipd_result_t);
    localparam int IPD_TDATA_W  = ((IPD_RESULT_W + 7) / 8) * 8;

    function automatic logic [3:0] digit_value(input logic [7:0] b);
        logic [7:0] d;
        d = b - CH_ZERO;
        if (b >= CH_ZERO && b <= CH_NINE)
            return d[3:0];
        return 4'd0;
    endfunction

endpackage

// ----- design/ipd_parser.sv -----
// ----------------------------------------------------------------------------
// ipd_parser
// Frame state and the combinational decision made for each accepted byte.
// ----------------------------------------------------------------------------
module ipd_parser
    import ipd_pkg::*;
#(
    parameter int MAX_PAYLOAD = IPD_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output ipd_result_t res
);

    logic       in_frame_reg,  in_frame_next;
    ipd_pos_t   pos_reg,       pos_next;
    logic [7:0] index_reg,     index_next;
    logic [3:0] length_reg,    length_next;
    logic [3:0] id_reg,        id_next;
    logic [7:0] first_reg,     first_next;

    logic [4:0] limit;
    logic       take_byte;
    logic       finish;
    logic       mismatch;
    logic [7:0] first_out;

    assign limit     = {1'b0, length_reg} + 5'd1;
    assign take_byte = (index_reg < {3'd0, limit}) && (index_reg < 8'(MAX_PAYLOAD))
                       && (rx_byte != CH_LF) && (rx_byte != CH_CR);
    assign finish    = in_frame_reg && (pos_reg == POS_PAYLOAD) && !take_byte;

    always_comb
    begin
        unique case (pos_reg)
            POS_I:      mismatch = (rx_byte != CH_I);
            POS_P:      mismatch = (rx_byte != CH_P);
            POS_D:      mismatch = (rx_byte != CH_D);
            POS_COMMA1: mismatch = (rx_byte != CH_COMMA);
            POS_COMMA2: mismatch = (rx_byte != CH_COMMA);
            POS_COLON:  mismatch = (rx_byte != CH_COLON);
            default:    mismatch = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        id_next       = id_reg;
        first_next    = first_reg;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == CH_PLUS)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_I;
                    index_next    = 8'd0;
                end
            end
            else if (pos_reg == POS_PAYLOAD)
            begin
                if (take_byte)
                begin
                    if (index_reg == 8'd0)
                        first_next = rx_byte;
                    index_next = index_reg + 8'd1;
                end
                else
                begin
                    in_frame_next = 1'b0;
                    index_next    = 8'd0;
                end
            end
            else
            begin
                if (pos_reg == POS_ID)
                    id_next = digit_value(rx_byte);
                if (pos_reg == POS_LEN)
                    length_next = digit_value(rx_byte);
                pos_next = ipd_pos_t'(pos_reg + 4'd1);
                if (mismatch)
                begin
                    in_frame_next = 1'b0;
                    index_next    = 8'd0;
                end
            end
        end
    end

    // Result logic.
    always_comb
    begin
        first_out           = (index_reg == 8'd0) ? 8'd0 : first_reg;
        res_valid           = accept && finish;
        res.conn_id         = id_reg;
        res.declared_length = length_reg;
        res.payload_count   = index_reg;
        res.first_byte      = first_out;
        res.command_valid   = (first_out >= CH_ZERO) && (first_out <= CH_TWO);
        res.command         = res.command_valid ? first_out[1:0] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= POS_I;
            index_reg    <= 8'd0;
            length_reg   <= 4'd0;
            id_reg       <= 4'd0;
            first_reg    <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            index_reg    <= index_next;
            length_reg   <= length_next;
            id_reg       <= id_next;
            first_reg    <= first_next;
        end
    end

    a_result_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (in_frame_reg && pos_reg == POS_PAYLOAD))
        else $error("result outside payload phase");

    a_leave_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (!in_frame_reg && index_reg == 8'd0))
        else $error("frame not closed after result");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (index_reg <= 8'(MAX_PAYLOAD)
                          && index_reg <= {3'd0, limit}))
        else $error("payload count past its limit");

    a_count_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (in_frame_reg && pos_reg != POS_PAYLOAD) |-> (index_reg == 8'd0))
        else $error("payload count moved during header");

endmodule

// ----- design/ipd_out_buf.sv -----
// ----------------------------------------------------------------------------
// ipd_out_buf
// Result register with a skid entry, so the parser keeps taking bytes while a
// finished result waits downstream.
// ----------------------------------------------------------------------------
module ipd_out_buf
    import ipd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ipd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ipd_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ipd_result_t out_data_reg,   out_data_next;
    ipd_result_t skid_data_reg,  skid_data_next;
    logic        push;
    logic        load_out;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign load_out  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg
                                           && out_data_reg == $past(skid_data_reg)))
        else $error("skid entry not forwarded");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

// ----- design/ipd_frame_command_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ipd_frame_command_parser_unit
// Parses "+IPD,c,n:payload" frames from a received byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle whenever s_tready is high. Each byte is
// decided in the same cycle it is accepted, against the registered frame
// state; the result for the byte that ends the frame is registered in the
// output register that drives m_tdata. That register is backed by a one-entry
// skid buffer, so s_tready drops only when two results are waiting downstream.
// Bytes outside a frame, and frames whose header does not match, produce no word.
module ipd_frame_command_parser_unit
    import ipd_pkg::*;
#(
    parameter int MAX_PAYLOAD = IPD_MAX_PAYLOAD
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] conn_id, [7:4] declared_length, [15:8] payload_count,
    // [23:16] first_byte, [24] command_valid, [26:25] command, rest zero
    output logic [IPD_TDATA_W-1:0] m_tdata
);

    logic        accept;
    logic        res_valid;
    ipd_result_t res;
    ipd_result_t out_res;

    assign accept = s_tvalid && s_tready;

    ipd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    ipd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = IPD_TDATA_W'(out_res);

endmodule
